### hdl/htcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htcf_pkg: shared types and constants of the hex text to CAN frame parser
// Field widths, status codes, the line state record and the hex decoder.
// ----------------------------------------------------------------------------
package htcf_pkg;

  // data bytes per frame and derived sizes
  localparam int MaxDataBytes = 8;
  localparam int DataDigits   = 2 * MaxDataBytes;
  localparam int PayloadW     = 8 * MaxDataBytes;
  localparam int CntW         = $clog2(DataDigits + 2);

  // fixed field widths
  localparam int ChW        = 8;
  localparam int IdW        = 11;
  localparam int ByteCountW = 4;
  localparam int NibbleW    = 4;
  localparam int HexValW    = 5;

  localparam logic [IdW-1:0]     IdLimit   = 11'h7FF;
  localparam logic [HexValW-1:0] HexRadix  = 5'd16;
  localparam logic [ChW-1:0]     PoundChar = 8'h23;
  localparam logic [CntW-1:0]    DigitLimit = CntW'(DataDigits);

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StFormat = 2'd1,
    StSize   = 2'd2,
    StId     = 2'd3
  } status_e;

  // everything the line accumulator knows about the current line
  typedef struct packed {
    logic                pound_seen;
    logic                bad_char_seen;
    logic [IdW-1:0]      id_accum;
    logic                id_too_big;
    logic                id_has_digit;
    logic [CntW-1:0]     data_char_count;
    logic [PayloadW-1:0] data_shift;
  } line_state_t;

  // nibble value of a hex digit, HexRadix when the character is not one
  function automatic logic [HexValW-1:0] hex_value(input logic [ChW-1:0] c);
    logic [HexValW-1:0] v;
    v = HexRadix;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = HexValW'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = HexValW'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = HexValW'(c - 8'h61 + 8'd10);
    end
    return v;
  endfunction

endpackage

### hdl/htcf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htcf_in_if: character channel
// One word is one ASCII character or a line terminator.
// ----------------------------------------------------------------------------
interface htcf_in_if;
  logic                       valid;
  logic                       ready;
  logic [htcf_pkg::ChW-1:0]   ch;
  logic                       end_of_line;

  modport source (output valid, output ch, output end_of_line, input ready);
  modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

### hdl/htcf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htcf_out_if: frame channel
// One word is a parsed frame or a status code for one line.
// ----------------------------------------------------------------------------
interface htcf_out_if;
  logic                              valid;
  logic                              ready;
  htcf_pkg::status_e                 status;
  logic [htcf_pkg::IdW-1:0]          frame_id;
  logic [htcf_pkg::ByteCountW-1:0]   byte_count;
  logic [htcf_pkg::PayloadW-1:0]     payload;

  modport source (output valid, output status, output frame_id, output byte_count,
                  output payload, input ready);
  modport sink   (input valid, input status, input frame_id, input byte_count,
                  input payload, output ready);
endinterface

### hdl/htcf_line_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htcf_line_acc: per-character line accumulator
// Decodes each character and updates identifier, data bytes, counts and flags.
// ----------------------------------------------------------------------------
module htcf_line_acc (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     take_i,
  input  logic                     clear_i,
  input  logic [htcf_pkg::ChW-1:0] ch_i,
  output htcf_pkg::line_state_t    state_o
);

  htcf_pkg::line_state_t state_q, state_d;

  logic [htcf_pkg::HexValW-1:0]       hex_v;
  logic                               is_hex;
  logic [htcf_pkg::IdW+3:0]           id_next;
  logic [htcf_pkg::NibbleW-1:0]       pending_nibble_q, pending_nibble_d;
  logic [7:0]                         data_byte;

  assign hex_v     = htcf_pkg::hex_value(ch_i);
  assign is_hex    = (hex_v != htcf_pkg::HexRadix);
  assign id_next   = {state_q.id_accum, hex_v[htcf_pkg::NibbleW-1:0]};
  assign data_byte = {pending_nibble_q, hex_v[htcf_pkg::NibbleW-1:0]};

  // next line state for one character
  always_comb begin
    state_d          = state_q;
    pending_nibble_d = pending_nibble_q;
    if (clear_i) begin
      state_d          = '0;
      pending_nibble_d = '0;
    end else if (take_i) begin
      if (!is_hex) begin
        if (!state_q.pound_seen && ch_i == htcf_pkg::PoundChar) begin
          state_d.pound_seen = 1'b1;
        end else begin
          state_d.bad_char_seen = 1'b1;
        end
      end else if (!state_q.pound_seen) begin
        // identifier digit, saturating above the limit
        state_d.id_has_digit = 1'b1;
        if (state_q.id_too_big || id_next[htcf_pkg::IdW+3:htcf_pkg::IdW] != '0) begin
          state_d.id_too_big = 1'b1;
          state_d.id_accum   = htcf_pkg::IdLimit;
        end else begin
          state_d.id_accum = id_next[htcf_pkg::IdW-1:0];
        end
      end else if (state_q.data_char_count < htcf_pkg::DigitLimit) begin
        // data digit: high nibble waits, low nibble completes the byte
        if (!state_q.data_char_count[0]) begin
          pending_nibble_d = hex_v[htcf_pkg::NibbleW-1:0];
        end else begin
          for (int b = 0; b < htcf_pkg::MaxDataBytes; b++) begin
            if (htcf_pkg::CntW'(state_q.data_char_count >> 1) == htcf_pkg::CntW'(b)) begin
              state_d.data_shift[8*b +: 8] = data_byte;
            end
          end
        end
        state_d.data_char_count = state_q.data_char_count + 1'b1;
      end else begin
        state_d.data_char_count = htcf_pkg::DigitLimit + 1'b1;
      end
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= '0;
      pending_nibble_q <= '0;
    end else begin
      state_q          <= state_d;
      pending_nibble_q <= pending_nibble_d;
    end
  end

  assign state_o = state_q;

  // a terminator leaves a fresh line
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> (state_q.data_char_count == '0 && !state_q.pound_seen &&
                 !state_q.id_has_digit && state_q.data_shift == '0))
    else $error("line state not cleared after terminator");

  // count never passes one above the digit limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.data_char_count <= htcf_pkg::DigitLimit + 1'b1)
    else $error("data digit count out of range");

  // identifier digits only before the pound sign
  a_id_before_pound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && !clear_i && state_q.pound_seen) |=> $stable(state_q.id_accum))
    else $error("identifier changed after pound sign");

endmodule

### hdl/hex_text_to_can_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_text_to_can_frame_parser: id#data command line to CAN data frame
// Parses one character per word and gives one frame or status per line.
// ----------------------------------------------------------------------------
// Accepts one character word per clock, back to back, and answers each
// terminator word with one result word in the next cycle; character words
// give no result. Each character updates the registered line state, and a
// result register with its own valid parts the output from the input. The
// input is ready whenever no result waits or the waiting one is taken in the
// same cycle, so a stalled output holds off every word, character or
// terminator, until the result is taken. Status is 0 ok, 1 format error (bad
// character, no '#', or no identifier digit), 2 data size error (odd digit
// count or more than 16 data digits), 3 identifier above 0x7FF, checked in
// that order; on any error the identifier, byte count and payload read zero.
module hex_text_to_can_frame_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  htcf_in_if.sink    in_i,
  htcf_out_if.source out_o
);

  htcf_pkg::line_state_t            line_state;
  logic                             in_fire;
  logic                             take_char;
  logic                             end_line;

  htcf_pkg::status_e                status_d, status_q;
  logic [htcf_pkg::IdW-1:0]         frame_id_d, frame_id_q;
  logic [htcf_pkg::ByteCountW-1:0]  byte_count_d, byte_count_q;
  logic [htcf_pkg::PayloadW-1:0]    payload_d, payload_q;
  logic                             out_valid_q;

  // input handshake
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign take_char  = in_fire && !in_i.end_of_line;
  assign end_line   = in_fire && in_i.end_of_line;

  htcf_line_acc u_line_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take_char),
    .clear_i (end_line),
    .ch_i    (in_i.ch),
    .state_o (line_state)
  );

  // line verdict, format first, then size, then identifier
  always_comb begin
    priority if (line_state.bad_char_seen || !line_state.pound_seen ||
                 !line_state.id_has_digit) begin
      status_d = htcf_pkg::StFormat;
    end else if (line_state.data_char_count > htcf_pkg::DigitLimit ||
                 line_state.data_char_count[0]) begin
      status_d = htcf_pkg::StSize;
    end else if (line_state.id_too_big) begin
      status_d = htcf_pkg::StId;
    end else begin
      status_d = htcf_pkg::StOk;
    end
  end

  // frame fields, zero unless the line is good
  always_comb begin
    frame_id_d   = '0;
    byte_count_d = '0;
    payload_d    = '0;
    if (status_d == htcf_pkg::StOk) begin
      frame_id_d   = line_state.id_accum;
      byte_count_d = htcf_pkg::ByteCountW'(line_state.data_char_count >> 1);
      payload_d    = line_state.data_shift;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (end_line) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (end_line) begin
      status_q     <= status_d;
      frame_id_q   <= frame_id_d;
      byte_count_q <= byte_count_d;
      payload_q    <= payload_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.frame_id   = frame_id_q;
  assign out_o.byte_count = byte_count_q;
  assign out_o.payload    = payload_q;

  // a terminator always yields a word next cycle
  a_eol_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_line |=> out_valid_q)
    else $error("terminator gave no result");

  // characters never create a result
  a_char_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_char && !out_valid_q) |=> !out_valid_q)
    else $error("result without terminator");

  // error results carry no frame content
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != htcf_pkg::StOk) |->
      (frame_id_q == '0 && byte_count_q == '0 && payload_q == '0))
    else $error("error result carries frame data");

  // good frames stay within the byte limit
  a_ok_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == htcf_pkg::StOk) |->
      byte_count_q <= htcf_pkg::ByteCountW'(htcf_pkg::MaxDataBytes))
    else $error("byte count above limit");

endmodule
